// ----- src/cprc_pkg.sv -----
// shared types, constants and helpers for the calorimeter point region classifier
// no dependencies
package cprc_pkg;

    localparam int NUM_LAYERS              = 8;
    localparam int HALF_TOWERS_PER_SIDE    = 2;
    localparam int HALF_CRYSTALS_PER_TOWER = 6;

    localparam int DW = 24;
    localparam int TQB = $clog2(2 * HALF_TOWERS_PER_SIDE + 1);
    localparam int LW  = $clog2(NUM_LAYERS + 1);
    localparam int NS  = (TQB > LW) ? TQB : LW;
    localparam int GW  = 21;
    localparam int GS  = GW;
    localparam int MW  = 15;
    localparam int AW  = 5;

    localparam logic [2:0] REG_TOWER_PITCH   = 3'd0;
    localparam logic [2:0] REG_CRACK_HALF    = 3'd1;
    localparam logic [2:0] REG_CELL_HOR      = 3'd2;
    localparam logic [2:0] REG_CRYSTAL_WIDTH = 3'd3;
    localparam logic [2:0] REG_CELL_VERT     = 3'd4;
    localparam logic [2:0] REG_CAL_TOP_Z     = 3'd5;

    localparam logic [1:0] REGION_GAP     = 2'd0;
    localparam logic [1:0] REGION_CRYSTAL = 2'd1;
    localparam logic [1:0] REGION_CRACK   = 2'd2;

    localparam logic [3:0] LAYER_NONE = 4'hF;

    typedef struct packed {
        logic [15:0]        tower_pitch;
        logic [14:0]        crack_half_width;
        logic [13:0]        cell_horizontal_pitch;
        logic [13:0]        crystal_width;
        logic [13:0]        cell_vertical_pitch;
        logic signed [19:0] cal_top_z;
    } t_cfg;

    typedef struct packed {
        logic          valid;
        logic          done;
        logic [1:0]    region;
        logic [3:0]    layer;
        logic          neg;
        logic [GW-1:0] mag;
    } t_mid;

    function automatic logic [DW-1:0] fold(input logic [DW-1:0] r, input logic [DW-1:0] m);
        logic [DW-1:0] d;
        d = m - r;
        return (d < r) ? d : r;
    endfunction

endpackage

// ----- src/calorimeter_point_region_classifier.sv -----
// top level: register port, bounds/tower pipeline and crystal gap pipeline
// depends on cprc_pkg, cprc_front, cprc_gap
//
// usage:
// - config: apb-style port, registers at byte addresses 0,4,..,20 in order tower_pitch,
//   crack_half_width, cell_horizontal_pitch, crystal_width, cell_vertical_pitch,
//   cal_top_z; write only while no word is in flight
// - input: a point word is taken at each clock edge with start high; busy stays low,
//   so a new word can enter every cycle
// - output: o_strobe marks a one-cycle result word (o_region, o_layer_index)
// - path: each word passes the tower and layer compare-subtract stages, then the crystal
//   pitch remainder stages and the output register
// - throughput: one word per cycle
// - reset clears all valid bits and loads the default geometry
// - the receiver cannot stall, so no word is ever held back
module calorimeter_point_region_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [19:0]        i_x_position,
    input  logic signed [19:0]        i_y_position,
    input  logic signed [19:0]        i_z_position,
    output logic                      o_strobe,
    output logic [1:0]                o_region,
    output logic signed [3:0]         o_layer_index,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cprc_pkg::AW-1:0]   paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    cprc_pkg::t_cfg r_cfg;
    cprc_pkg::t_mid mid;
    logic [3:0]     layer;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tower_pitch           <= 16'd23968;
            r_cfg.crack_half_width      <= 15'd1423;
            r_cfg.cell_horizontal_pitch <= 14'd1782;
            r_cfg.crystal_width         <= 14'd1709;
            r_cfg.cell_vertical_pitch   <= 14'd1366;
            r_cfg.cal_top_z             <= -20'sd3033;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                cprc_pkg::REG_TOWER_PITCH:   r_cfg.tower_pitch <= pwdata[15:0];
                cprc_pkg::REG_CRACK_HALF:    r_cfg.crack_half_width <= pwdata[14:0];
                cprc_pkg::REG_CELL_HOR:      r_cfg.cell_horizontal_pitch <= pwdata[13:0];
                cprc_pkg::REG_CRYSTAL_WIDTH: r_cfg.crystal_width <= pwdata[13:0];
                cprc_pkg::REG_CELL_VERT:     r_cfg.cell_vertical_pitch <= pwdata[13:0];
                cprc_pkg::REG_CAL_TOP_Z:     r_cfg.cal_top_z <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cprc_pkg::REG_TOWER_PITCH:   prdata = 32'(r_cfg.tower_pitch);
            cprc_pkg::REG_CRACK_HALF:    prdata = 32'(r_cfg.crack_half_width);
            cprc_pkg::REG_CELL_HOR:      prdata = 32'(r_cfg.cell_horizontal_pitch);
            cprc_pkg::REG_CRYSTAL_WIDTH: prdata = 32'(r_cfg.crystal_width);
            cprc_pkg::REG_CELL_VERT:     prdata = 32'(r_cfg.cell_vertical_pitch);
            cprc_pkg::REG_CAL_TOP_Z:     prdata = {12'b0, r_cfg.cal_top_z};
            default:                     prdata = '0;
        endcase
    end

    cprc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_x     (i_x_position),
        .i_y     (i_y_position),
        .i_z     (i_z_position),
        .i_cfg   (r_cfg),
        .o_mid   (mid)
    );

    cprc_gap u_gap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mid    (mid),
        .i_cfg    (r_cfg),
        .o_strobe (o_strobe),
        .o_region (o_region),
        .o_layer  (layer)
    );

    assign o_layer_index = $signed(layer);

endmodule

// ----- src/cprc_front.sv -----
// bounds check, tower remainder and layer division pipeline
// depends on cprc_pkg
module cprc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [19:0] i_x,
    input  logic signed [19:0] i_y,
    input  logic signed [19:0] i_z,
    input  cprc_pkg::t_cfg     i_cfg,
    output cprc_pkg::t_mid     o_mid
);
    localparam int DW = cprc_pkg::DW;
    localparam int NS = cprc_pkg::NS;
    localparam int LW = cprc_pkg::LW;
    localparam int GW = cprc_pkg::GW;

    logic                 r_v   [0:NS];
    logic                 r_out [0:NS];
    logic [DW-1:0]        r_ax  [0:NS];
    logic [DW-1:0]        r_ay  [0:NS];
    logic [DW-1:0]        r_dz  [0:NS];
    logic [LW-1:0]        r_q   [0:NS];
    logic [DW-1:0]        n_ax  [0:NS-1];
    logic [DW-1:0]        n_ay  [0:NS-1];
    logic [DW-1:0]        n_dz  [0:NS-1];
    logic [LW-1:0]        n_q   [0:NS-1];

    logic [DW-1:0]        tp, vp, hp, half;
    logic signed [DW-1:0] xs, ys, zs, hs, top, bot;
    logic                 n_out;
    logic [DW-1:0]        xmod, ymod, sel, a_u, mag;
    logic [LW-1:0]        lay;
    cprc_pkg::t_mid       n_mid;

    always_comb begin
        tp    = DW'(i_cfg.tower_pitch);
        vp    = DW'(i_cfg.cell_vertical_pitch);
        hp    = DW'(i_cfg.cell_horizontal_pitch);
        half  = DW'(cprc_pkg::HALF_TOWERS_PER_SIDE) * tp;
        hs    = $signed(half);
        xs    = DW'(i_x);
        ys    = DW'(i_y);
        zs    = DW'(i_z);
        top   = DW'(i_cfg.cal_top_z);
        bot   = top - $signed(DW'(cprc_pkg::NUM_LAYERS) * vp);
        n_out = (tp == '0) || (hp == '0) || (vp == '0) || (zs > top) || (zs < bot)
             || (xs > hs) || (-xs > hs) || (ys > hs) || (-ys > hs);
    end

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            n_ax[k] = (r_ax[k] >= (tp << (NS - 1 - k))) ? r_ax[k] - (tp << (NS - 1 - k))
                                                        : r_ax[k];
            n_ay[k] = (r_ay[k] >= (tp << (NS - 1 - k))) ? r_ay[k] - (tp << (NS - 1 - k))
                                                        : r_ay[k];
            n_dz[k] = (r_dz[k] >= (vp << (NS - 1 - k))) ? r_dz[k] - (vp << (NS - 1 - k))
                                                        : r_dz[k];
            n_q[k]  = (r_q[k] << 1) | LW'(r_dz[k] >= (vp << (NS - 1 - k)));
        end
    end

    // fold, crack test, layer clamp and crystal grid offset
    always_comb begin
        xmod = cprc_pkg::fold(r_ax[NS], tp);
        ymod = cprc_pkg::fold(r_ay[NS], tp);
        lay  = (r_q[NS] > LW'(cprc_pkg::NUM_LAYERS - 1)) ? LW'(cprc_pkg::NUM_LAYERS - 1)
                                                          : r_q[NS];
        sel  = lay[0] ? xmod : ymod;
        a_u  = (sel << 1) - tp + DW'(2 * cprc_pkg::HALF_CRYSTALS_PER_TOWER) * hp;
        mag  = a_u[DW-1] ? -a_u : a_u;
        n_mid.valid = r_v[NS];
        n_mid.neg   = a_u[DW-1];
        n_mid.mag   = GW'(mag);
        n_mid.layer = 4'(lay);
        if (r_out[NS]) begin
            n_mid.done   = 1'b1;
            n_mid.region = cprc_pkg::REGION_GAP;
        end else if (xmod < DW'(i_cfg.crack_half_width)
                  || ymod < DW'(i_cfg.crack_half_width)) begin
            n_mid.done   = 1'b1;
            n_mid.region = cprc_pkg::REGION_CRACK;
        end else begin
            n_mid.done   = 1'b0;
            n_mid.region = cprc_pkg::REGION_CRYSTAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_v[k] <= 1'b0;
            o_mid <= '0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NS; k++) r_v[k+1] <= r_v[k];
            o_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out[0] <= n_out;
        r_ax[0]  <= DW'(xs + hs);
        r_ay[0]  <= DW'(ys + hs);
        r_dz[0]  <= DW'(top - zs);
        r_q[0]   <= '0;
        for (int k = 0; k < NS; k++) begin
            r_out[k+1] <= r_out[k];
            r_ax[k+1]  <= n_ax[k];
            r_ay[k+1]  <= n_ay[k];
            r_dz[k+1]  <= n_dz[k];
            r_q[k+1]   <= n_q[k];
        end
    end

endmodule

// ----- src/cprc_gap.sv -----
// crystal pitch remainder pipeline and inter-crystal gap decision with output register
// depends on cprc_pkg
module cprc_gap (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cprc_pkg::t_mid i_mid,
    input  cprc_pkg::t_cfg i_cfg,
    output logic           o_strobe,
    output logic [1:0]     o_region,
    output logic [3:0]     o_layer
);
    localparam int GW = cprc_pkg::GW;
    localparam int GS = cprc_pkg::GS;
    localparam int MW = cprc_pkg::MW;
    localparam int DW = cprc_pkg::DW;

    cprc_pkg::t_mid        r_st [0:GS];
    cprc_pkg::t_mid        n_st [0:GS-1];
    logic [MW-1:0]         m2, rem, r2;
    logic [DW-1:0]         f;
    logic signed [MW:0]    thr;
    logic                  gap;
    logic [1:0]            n_region;
    logic [3:0]            n_layer;

    assign m2 = {i_cfg.cell_horizontal_pitch, 1'b0};

    always_comb begin
        for (int k = 0; k < GS; k++) begin
            n_st[k] = r_st[k];
            if ((GW + MW)'(r_st[k].mag) >= ((GW + MW)'(m2) << (GW - 1 - k)))
                n_st[k].mag = GW'((GW + MW)'(r_st[k].mag) - ((GW + MW)'(m2) << (GW - 1 - k)));
        end
    end

    always_comb begin
        rem = MW'(r_st[GS].mag);
        r2  = (r_st[GS].neg && rem != '0) ? m2 - rem : rem;
        f   = cprc_pkg::fold(DW'(r2), DW'(m2));
        thr = $signed({2'b0, i_cfg.cell_horizontal_pitch})
            - $signed({2'b0, i_cfg.crystal_width});
        gap = $signed({1'b0, MW'(f)}) < thr;
        if (r_st[GS].done) begin
            n_region = r_st[GS].region;
            n_layer  = cprc_pkg::LAYER_NONE;
        end else if (gap) begin
            n_region = cprc_pkg::REGION_GAP;
            n_layer  = cprc_pkg::LAYER_NONE;
        end else begin
            n_region = cprc_pkg::REGION_CRYSTAL;
            n_layer  = r_st[GS].layer;
        end
    end

    always_ff @(posedge i_clk) begin
        o_region <= n_region;
        o_layer  <= n_layer;
        if (!i_rst_n) begin
            for (int k = 0; k <= GS; k++) r_st[k] <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_st[0] <= i_mid;
            for (int k = 0; k < GS; k++) r_st[k+1] <= n_st[k];
            o_strobe <= r_st[GS].valid;
        end
    end

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_region != 2'd3) else $error("bad region code");
    a_layer_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_region != cprc_pkg::REGION_CRYSTAL |-> o_layer == cprc_pkg::LAYER_NONE)
        else $error("layer set outside crystal");
    a_layer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_region == cprc_pkg::REGION_CRYSTAL
        |-> o_layer <= 4'(cprc_pkg::NUM_LAYERS - 1)) else $error("layer out of range");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("word after reset");

endmodule

// ----- tb/sv/calorimeter_point_region_classifier_tb.sv -----
// self-checking testbench for calorimeter_point_region_classifier: directed table then random
// points, checked against an in-bench geometry classifier; config written over the apb port
// depends on cprc_pkg and the calorimeter_point_region_classifier rtl
module calorimeter_point_region_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0] region;
        logic [3:0] layer;
    } t_class;

    typedef struct {
        int         x;
        int         y;
        int         z;
        bit         typed;
        logic [1:0] region;
        logic [3:0] layer;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [19:0]        i_x_position;
    logic signed [19:0]        i_y_position;
    logic signed [19:0]        i_z_position;
    logic                      o_strobe;
    logic [1:0]                o_region;
    logic signed [3:0]         o_layer_index;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [cprc_pkg::AW-1:0]   paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    calorimeter_point_region_classifier dut (.*);

    longint geo_tp, geo_chw, geo_hp, geo_cw, geo_vp, geo_top;
    t_class expected_q[$];
    int     fail_count;
    int     cycle_count;
    bit     tail_mode;

    localparam int LATENCY_WAIT = 80;
    localparam int CYCLE_LIMIT  = 400000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_mod(longint a, longint m);
        longint r;
        r = a % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic longint wall_dist(longint r, longint m);
        return (m - r < r) ? m - r : r;
    endfunction

    function automatic t_class classify_point(longint x, longint y, longint z);
        t_class c;
        longint bot, half, xm, ym, layer, sel, d2;
        c.region = cprc_pkg::REGION_GAP;
        c.layer  = cprc_pkg::LAYER_NONE;
        if (geo_tp == 0 || geo_hp == 0 || geo_vp == 0) return c;
        bot = geo_top - cprc_pkg::NUM_LAYERS * geo_vp;
        if (z > geo_top || z < bot) return c;
        half = cprc_pkg::HALF_TOWERS_PER_SIDE * geo_tp;
        if (x > half || -x > half || y > half || -y > half) return c;
        xm = wall_dist(floor_mod(x + half, geo_tp), geo_tp);
        ym = wall_dist(floor_mod(y + half, geo_tp), geo_tp);
        if (xm < geo_chw || ym < geo_chw) begin
            c.region = cprc_pkg::REGION_CRACK;
            return c;
        end
        layer = (geo_top - z) / geo_vp;
        if (layer > cprc_pkg::NUM_LAYERS - 1) layer = cprc_pkg::NUM_LAYERS - 1;
        sel = layer[0] ? xm : ym;
        d2 = 2 * sel - geo_tp + 2 * cprc_pkg::HALF_CRYSTALS_PER_TOWER * geo_hp;
        d2 = wall_dist(floor_mod(d2, 2 * geo_hp), 2 * geo_hp);
        if (d2 < geo_hp - geo_cw) return c;
        c.region = cprc_pkg::REGION_CRYSTAL;
        c.layer  = layer[3:0];
        return c;
    endfunction

    function automatic int rand20();
        return $signed(20'($urandom));
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("calorimeter_point_region_classifier regression: fail");
            $finish;
        end
        if (o_strobe) begin
            if (expected_q.size() == 0) begin
                $error("unexpected word region=%0d layer=%0d", o_region, o_layer_index);
                fail_count++;
            end else begin
                t_class e;
                e = expected_q.pop_front();
                if (o_region !== e.region) begin
                    $error("region expected %0d actual %0d", e.region, o_region);
                    fail_count++;
                end
                if (o_layer_index !== e.layer) begin
                    $error("layer_index expected %0d actual %0d", e.layer, o_layer_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, longint value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cprc_pkg::AW'(idx) << 2;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cprc_pkg::REG_TOWER_PITCH:   geo_tp  = value & 16'hFFFF;
            cprc_pkg::REG_CRACK_HALF:    geo_chw = value & 15'h7FFF;
            cprc_pkg::REG_CELL_HOR:      geo_hp  = value & 14'h3FFF;
            cprc_pkg::REG_CRYSTAL_WIDTH: geo_cw  = value & 14'h3FFF;
            cprc_pkg::REG_CELL_VERT:     geo_vp  = value & 14'h3FFF;
            default:                     geo_top = $signed(20'(value));
        endcase
    endtask

    task automatic set_geometry(longint tp, longint chw, longint hp, longint cw, longint vp,
                                longint top);
        wait_drain();
        reg_write(cprc_pkg::REG_TOWER_PITCH, tp);
        reg_write(cprc_pkg::REG_CRACK_HALF, chw);
        reg_write(cprc_pkg::REG_CELL_HOR, hp);
        reg_write(cprc_pkg::REG_CRYSTAL_WIDTH, cw);
        reg_write(cprc_pkg::REG_CELL_VERT, vp);
        reg_write(cprc_pkg::REG_CAL_TOP_Z, top);
    endtask

    // drives one point; leaves start high so back-to-back words stay clean
    task automatic send_point(int x, int y, int z, bit typed, t_class want);
        t_class p;
        if (!tail_mode && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_x_position <= 20'(x);
        i_y_position <= 20'(y);
        i_z_position <= 20'(z);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        p = classify_point($signed(20'(x)), $signed(20'(y)), $signed(20'(z)));
        if (typed && (p.region !== want.region || p.layer !== want.layer))
            $error("table row disagrees with classifier at %0d %0d %0d", x, y, z);
        expected_q.push_back(typed ? want : p);
    endtask

    task automatic idle_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // point in the current geometry, mostly inside the calorimeter volume
    task automatic send_random_point();
        longint half, bot;
        int x, y, z;
        half = cprc_pkg::HALF_TOWERS_PER_SIDE * geo_tp;
        bot  = geo_top - cprc_pkg::NUM_LAYERS * geo_vp;
        if ($urandom_range(0, 9) < 8 && geo_tp != 0) begin
            x = int'(longint'($urandom_range(0, 2 * half)) - half);
            y = int'(longint'($urandom_range(0, 2 * half)) - half);
            z = (bot < -524288) ? int'(geo_top) - int'($urandom_range(0, 1000))
                                : int'(bot) + int'($urandom_range(0, geo_top - bot));
            if ($urandom_range(0, 19) == 0) z = int'(bot);
        end else begin
            x = rand20();
            y = rand20();
            z = rand20();
        end
        send_point(x, y, z, 1'b0, '{cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE});
    endtask

    t_row dir_tab[] = '{
        '{0, 0, 0, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{47936, 47936, -3033, 1'b1, cprc_pkg::REGION_CRACK, cprc_pkg::LAYER_NONE},
        '{47937, 0, -3033, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{0, -47937, -3033, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{0, 0, -3032, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{0, 0, -13961, 1'b1, cprc_pkg::REGION_CRACK, cprc_pkg::LAYER_NONE},
        '{524287, 524287, 524287, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{-524288, -524288, -524288, 1'b1, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{12000, 12000, -3033, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{12000, 12000, -13960, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{12000, 12000, -4399, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{12000, 12891, -5000, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{11000, 12891, -5000, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{-12000, -12500, -8000, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE},
        '{23968, 100, -6000, 1'b1, cprc_pkg::REGION_CRACK, cprc_pkg::LAYER_NONE},
        '{-34000, 34000, -12000, 1'b0, cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE}
    };

    initial begin
        t_class w;
        fail_count   = 0;
        cycle_count  = 0;
        tail_mode    = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_x_position = '0;
        i_y_position = '0;
        i_z_position = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        geo_tp = 23968; geo_chw = 1423; geo_hp = 1782;
        geo_cw = 1709;  geo_vp = 1366;  geo_top = -3033;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            w.region = dir_tab[i].region;
            w.layer  = dir_tab[i].layer;
            send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, w);
        end
        for (int i = 0; i < 100; i++) send_random_point();
        idle_start();

        // zero pitch and wide crystal corners
        set_geometry(0, 0, 1782, 1709, 1366, -3033);
        for (int i = 0; i < 5; i++) send_random_point();
        send_point(0, 0, -3033, 1'b1, '{cprc_pkg::REGION_GAP, cprc_pkg::LAYER_NONE});
        idle_start();
        set_geometry(100, 0, 7, 16383, 1, 0);
        for (int i = 0; i < 60; i++) send_random_point();
        idle_start();
        set_geometry(65535, 32767, 16383, 0, 16383, 524287);
        for (int i = 0; i < 60; i++) send_random_point();
        idle_start();
        set_geometry(1, 0, 1, 0, 1, -524288);
        for (int i = 0; i < 20; i++) send_random_point();
        idle_start();
        set_geometry(3000, 150, 220, 200, 50, 1000);
        for (int i = 0; i < 100; i++) send_random_point();
        idle_start();
        set_geometry(23968, 1423, 1782, 1709, 1366, -3033);
        tail_mode = 1'b1;
        for (int i = 0; i < 100; i++) send_random_point();
        idle_start();

        wait_drain();
        if (fail_count == 0) begin
            $display("calorimeter_point_region_classifier regression: pass");
        end else begin
            $display("calorimeter_point_region_classifier regression: fail");
        end
        $finish;
    end
endmodule
